[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [31:0]        value;
    logic signed [15:0] prio;
  } entry_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    logic   clr;
    entry_t item;
  } cell_cmd_t;

endpackage

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               left_go,
  input  spq_pkg::entry_t    left_ent,
  input  logic               left_valid,
  input  spq_pkg::entry_t    right_ent,
  input  logic               right_valid,
  output logic               go,
  output spq_pkg::entry_t    ent,
  output logic               valid
);

  // go: new item belongs at or ahead of this cell; monotonic along the chain
  assign go = !valid || (ent.prio <= cmd.item.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.enq) begin
      if (go && !left_go) begin
        valid <= 1'b1;
      end else if (go) begin
        valid <= left_valid;
      end
    end else if (cmd.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (go && !left_go) begin
        ent <= cmd.item;
      end else if (go) begin
        ent <= left_ent;
      end
    end else if (cmd.deq) begin
      ent <= right_ent;
    end
  end

endmodule

[rtl/core/sorted_priority_queue.sv]
// The done strobe carrying the result is registered: it rises in the cycle after start.
// Throughput: one operation per cycle; busy stays low, every chain cell
// updates in the same cycle as its neighbors.
// Reset (rst, synchronous): queue empty, count zero, no strobe pending.
// Results are shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [31:0]        item_value,
  input  logic signed [15:0] item_priority,
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        out_value,
  output logic signed [15:0] out_priority,
  output logic [4:0]         entry_count,
  output logic               is_empty,
  output logic               is_full
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  // Chain state: cell 0 is the front (highest priority).
  spq_pkg::entry_t    cell_ent   [N];
  logic [N-1:0]       cell_valid;
  logic [N-1:0]       cell_go;
  spq_pkg::cell_cmd_t cmd;

  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;

  logic       xfer;
  logic       q_full;
  logic       q_empty;
  logic [1:0] status_next;
  spq_pkg::entry_t front;

  // Every transfer is a single chain update, so the block never holds off start.
  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign q_full  = (count == spq_pkg::CNT_W'(N));
  assign q_empty = (count == '0);
  assign front   = cell_ent[0];

  // Decode the transfer into a chain command; refused operations do nothing.
  always_comb begin
    cmd.enq     = 1'b0;
    cmd.deq     = 1'b0;
    cmd.clr     = 1'b0;
    cmd.item    = '{value: item_value, prio: item_priority};
    status_next = spq_pkg::ST_OK;
    count_next  = count;
    if (xfer) begin
      unique case (operation)
        spq_pkg::OP_ENQUEUE: begin
          if (q_full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            cmd.enq    = 1'b1;
            count_next = count + 1'b1;
          end
        end
        spq_pkg::OP_DEQUEUE: begin
          if (q_empty) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            cmd.deq    = 1'b1;
            count_next = count - 1'b1;
          end
        end
        spq_pkg::OP_CLEAR: begin
          cmd.clr    = 1'b1;
          count_next = '0;
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
  end

  // Row of cells. Enqueue: each cell either keeps its entry, takes the new
  // item (first cell whose go is set) or takes its left neighbor's entry.
  // Dequeue: every cell takes its right neighbor's entry.
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t l_ent;
    spq_pkg::entry_t r_ent;
    logic            l_go;
    logic            l_valid;
    logic            r_valid;

    if (i == 0) begin : g_head
      assign l_go    = 1'b0;
      assign l_ent   = cmd.item;
      assign l_valid = 1'b0;
    end else begin : g_body
      assign l_go    = cell_go[i-1];
      assign l_ent   = cell_ent[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_ent   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_ent   = cell_ent[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_go     (l_go),
      .left_ent    (l_ent),
      .left_valid  (l_valid),
      .right_ent   (r_ent),
      .right_valid (r_valid),
      .go          (cell_go[i]),
      .ent         (cell_ent[i]),
      .valid       (cell_valid[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= xfer;
    end
  end

  // Result registers; out_value/out_priority carry the front only on a
  // successful dequeue.
  always_ff @(posedge clk) begin
    status      <= status_next;
    entry_count <= 5'(count_next);
    is_empty    <= (count_next == '0);
    is_full     <= (count_next == spq_pkg::CNT_W'(N));
    if (cmd.deq) begin
      out_value    <= front.value;
      out_priority <= front.prio;
    end else begin
      out_value    <= '0;
      out_priority <= '0;
    end
  end

  // Occupied cells must match the count.
  `SPQ_ASSERT_ALWAYS(a_count_cells, clk, rst,
    spq_pkg::CNT_W'($countones(cell_valid)) == count)
  // Front never outranked by the second entry.
  `SPQ_ASSERT_ALWAYS(a_sorted_front, clk, rst,
    !cell_valid[1] || (cell_ent[0].prio >= cell_ent[1].prio))
  // Every transfer yields exactly one strobe next cycle.
  `SPQ_ASSERT_NEXT(a_one_result, clk, rst, xfer, done)
  // A refused enqueue leaves the count unchanged.
  `SPQ_ASSERT_NEXT(a_full_hold, clk, rst,
    xfer && (operation == spq_pkg::OP_ENQUEUE) && q_full,
    (status == spq_pkg::ST_FULL) && $stable(count))

endmodule
